[hdl/line_fit_gradient_descent_unit_defines.svh]
`ifndef LINE_FIT_GRADIENT_DESCENT_UNIT_DEFINES_SVH
`define LINE_FIT_GRADIENT_DESCENT_UNIT_DEFINES_SVH

// checks that stay quiet while reset is high
`define LFGD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checks that also hold through reset
`define LFGD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[hdl/lfgd_pkg.sv]
`default_nettype none

package lfgd_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CSR_IDX_W  = 3;

   localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] START_ERR = 64'h0000_0064_0000_0000;
   localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE    = 3'd0,
      CSR_TOLERANCE    = 3'd1,
      CSR_MAX_ITER     = 3'd2,
      CSR_SLOPE_DELTA  = 3'd3,
      CSR_OFFSET_DELTA = 3'd4,
      CSR_START_SLOPE  = 3'd5,
      CSR_START_OFFSET = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_MUL16,
      OP_MUL32,
      OP_DIV,
      OP_SQRT
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } arith_sts_type;

   function automatic logic [63:0] mag(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic neg);
      if (neg) begin
         return m[63] ? Q_MIN : (64'd0 - m);
      end
      return m[63] ? Q_MAX : m;
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? Q_MIN : Q_MAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         return a[63] ? Q_MIN : Q_MAX;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

[hdl/lfgd_arith.sv]
`default_nettype none

module lfgd_arith (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lfgd_pkg::arith_ctl_type ctl,
   input  wire logic [63:0]           opa,
   input  wire logic [63:0]           opb,
   output lfgd_pkg::arith_sts_type    sts,
   output logic [63:0]                result
);
   import lfgd_pkg::*;

   typedef enum logic [2:0] {
      A_IDLE, A_MUL, A_MFIN, A_DCHK, A_DIV, A_DFIN, A_SQRT, A_QFIN
   } arith_state_type;

   arith_state_type state_ff;
   arith_op_type    op_ff;
   logic            neg_ff;
   logic            done_ff;
   logic [5:0]      cnt_ff;
   logic [63:0]     ma_ff, mb_ff;
   logic [127:0]    acc_ff;
   logic [63:0]     rem_ff, lo_ff, quo_ff;
   logic [95:0]     rad_ff;
   logic [47:0]     root_ff;
   logic [49:0]     srem_ff;
   logic [63:0]     result_ff;

   logic [63:0]  mag_a, mag_b;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_in;
   logic [63:0]  mul_m;
   logic [63:0]  r2;
   logic         take;
   logic [63:0]  rem_in;
   logic [51:0]  trem, trial, tdiff;
   logic         sq_ge;

   always_comb begin
      mag_a  = mag(opa);
      mag_b  = mag(opb);
      a_half = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_half = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp     = a_half * b_half;
      // partial product weight follows the two half selects
      case ({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]})
         2'd0:    pp_in = {64'd0, pp};
         2'd1:    pp_in = {32'd0, pp, 32'd0};
         default: pp_in = {pp, 64'd0};
      endcase
      if (op_ff == OP_MUL16) begin
         mul_m = (|acc_ff[127:80]) ? '1 : acc_ff[79:16];
      end else begin
         mul_m = (|acc_ff[127:96]) ? '1 : acc_ff[95:32];
      end
      r2     = {rem_ff[62:0], lo_ff[63]};
      take   = rem_ff[63] || (r2 >= mb_ff);
      rem_in = take ? (r2 - mb_ff) : r2;
      trem   = {srem_ff, rad_ff[95:94]};
      trial  = {2'b00, root_ff, 2'b01};
      sq_ge  = trem >= trial;
      tdiff  = trem - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == A_MFIN) || (state_ff == A_DFIN) || (state_ff == A_QFIN);
         unique case (state_ff)
            A_IDLE: begin
               if (ctl.start) begin
                  op_ff  <= ctl.op;
                  neg_ff <= opa[63] ^ opb[63];
                  ma_ff  <= mag_a;
                  mb_ff  <= mag_b;
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  unique case (ctl.op) inside
                     OP_MUL16, OP_MUL32: state_ff <= A_MUL;
                     OP_DIV: begin
                        rem_ff   <= {32'd0, mag_a[63:32]};
                        lo_ff    <= {mag_a[31:0], 32'd0};
                        quo_ff   <= '0;
                        state_ff <= A_DCHK;
                     end
                     OP_SQRT: begin
                        rad_ff   <= {opa, 32'd0};
                        root_ff  <= '0;
                        srem_ff  <= '0;
                        state_ff <= A_SQRT;
                     end
                     default: state_ff <= A_IDLE;
                  endcase
               end
            end
            A_MUL: begin
               acc_ff <= acc_ff + pp_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd3) begin
                  state_ff <= A_MFIN;
               end
            end
            A_MFIN: begin
               result_ff <= signed_sat(mul_m, neg_ff);
               state_ff  <= A_IDLE;
            end
            A_DCHK: begin
               // quotient would not fit in 64 bits
               if (rem_ff >= mb_ff) begin
                  quo_ff   <= '1;
                  state_ff <= A_DFIN;
               end else begin
                  state_ff <= A_DIV;
               end
            end
            A_DIV: begin
               rem_ff <= rem_in;
               lo_ff  <= {lo_ff[62:0], 1'b0};
               quo_ff <= {quo_ff[62:0], take};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= A_DFIN;
               end
            end
            A_DFIN: begin
               result_ff <= signed_sat(quo_ff, neg_ff);
               state_ff  <= A_IDLE;
            end
            A_SQRT: begin
               srem_ff <= sq_ge ? tdiff[49:0] : trem[49:0];
               root_ff <= {root_ff[46:0], sq_ge};
               rad_ff  <= {rad_ff[93:0], 2'b00};
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd47) begin
                  state_ff <= A_QFIN;
               end
            end
            A_QFIN: begin
               result_ff <= {16'd0, root_ff};
               state_ff  <= A_IDLE;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign sts.done = done_ff;
   assign sts.busy = (state_ff != A_IDLE);
   assign result   = result_ff;

`include "line_fit_gradient_descent_unit_defines.svh"

   `LFGD_ASSERT_ALWAYS(a_done_pulse, done_ff |=> !done_ff, "done held over one cycle")
   `LFGD_ASSERT(a_done_src, done_ff |-> $past(state_ff == A_MFIN || state_ff == A_DFIN || state_ff == A_QFIN), "done without a finish step")
   `LFGD_ASSERT(a_sqrt_count, (state_ff == A_SQRT) |-> (cnt_ff < 6'd48), "root digit count overrun")

endmodule

`default_nettype wire

[hdl/line_fit_gradient_descent_unit.sv]
// channel  | handshake              | payload
// req      | req_valid / req_ready  | req_point_x, req_point_y, req_last_point
// rsp      | rsp_valid / rsp_ready  | rsp_fit_slope, rsp_fit_offset, rsp_iterations_used,
//          |                        | rsp_final_step, rsp_converged
// csr      | csr_we (no wait)       | csr_index, csr_wdata
//
// points load one beat per cycle into the point memory; a last point starts the fit
// and req_ready stays low until the result is placed in the output register.
// one fit iteration makes four cost passes over N points on the shared multi-cycle
// arith unit, which has a 64-step divider. a fit waits in its final step while a
// previous result stalls. reset is synchronous; it restores the configuration and
// control registers and clears the point count.
`default_nettype none

module line_fit_gradient_descent_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [31:0]             req_point_x,
   input  wire logic signed [31:0]             req_point_y,
   input  wire logic                           req_last_point,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [63:0]                  rsp_fit_slope,
   output logic signed [63:0]                  rsp_fit_offset,
   output logic [16:0]                         rsp_iterations_used,
   output logic [62:0]                         rsp_final_step,
   output logic                                rsp_converged,
   input  wire logic                           csr_we,
   input  wire logic [lfgd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                    csr_wdata
);
   import lfgd_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD, S_INIT, S_CHECK, S_SQ1, S_SQ2, S_SQ3, S_STEP,
      S_G1A, S_G1B, S_G1C, S_G1D, S_G2A, S_G2B, S_G2C, S_G2D,
      S_C_BEGIN, S_C_RD, S_C_PT, S_C_RES, S_C_ACC, S_C_DEN, S_C_DIV, S_C_END,
      S_WAIT, S_FINISH
   } state_type;

   // configuration
   logic [62:0] step_size_ff, tolerance_ff, slope_delta_ff, offset_delta_ff;
   logic [15:0] max_iter_ff;
   logic [63:0] start_slope_ff, start_offset_ff;

   // fit state
   state_type   state_ff, after_ff, cost_ret_ff;
   logic [CNT_W-1:0] pt_count_ff, pt_idx_ff;
   logic [63:0] slope_ff, offset_ff, slope_prev_ff, offset_prev_ff;
   logic [63:0] err_ff;
   logic [16:0] iter_ff;
   logic [63:0] ca_ff, cb_ff, sum_ff, yq_ff, cost_ff, base_ff, tmp_ff;

   // arith unit link
   arith_ctl_type arith_ctl_ff;
   arith_sts_type arith_sts;
   logic [63:0]   opa_ff, opb_ff, arith_res;
   logic          issue_in;
   arith_op_type  issue_op_in;

   // point memory
   logic [63:0]      pt_mem [MAX_POINTS];
   logic [63:0]      rd_data_ff;
   logic [IDX_W-1:0] rd_addr_in, wr_addr_in;
   logic             wr_en_in;

   logic rsp_valid_ff;
   logic [63:0] rsp_slope_ff, rsp_offset_ff;
   logic [16:0] rsp_iter_ff;
   logic [62:0] rsp_step_ff;
   logic        rsp_conv_ff;
   logic        fin_take_in;

   logic [63:0] ds_in, dof_in, da_in, db_in, resid_in, slope_in, offset_in;
   logic [CNT_W-1:0] idx_next_in;

   assign req_ready = (state_ff == S_LOAD);

   always_comb begin
      ds_in       = (slope_delta_ff == '0) ? 64'd1 : {1'b0, slope_delta_ff};
      dof_in      = (offset_delta_ff == '0) ? 64'd1 : {1'b0, offset_delta_ff};
      da_in       = sat_sub(slope_ff, slope_prev_ff);
      db_in       = sat_sub(offset_ff, offset_prev_ff);
      resid_in    = sat_sub(sat_sub(yq_ff, arith_res), cb_ff);
      slope_in    = sat_sub(slope_ff, arith_res);
      offset_in   = sat_sub(offset_ff, arith_res);
      idx_next_in = pt_idx_ff + 1'b1;
      rd_addr_in  = pt_idx_ff[IDX_W-1:0];
      wr_addr_in  = pt_count_ff[IDX_W-1:0];
      wr_en_in    = req_valid && req_ready && (pt_count_ff < CNT_W'(MAX_POINTS));
      fin_take_in = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // arith issue decode
   always_comb begin
      issue_in    = 1'b1;
      issue_op_in = OP_MUL32;
      unique case (state_ff)
         S_SQ1, S_SQ2, S_G1C, S_G2C, S_C_RES, S_C_DEN: issue_op_in = OP_MUL32;
         S_SQ3:                                        issue_op_in = OP_SQRT;
         S_G1B, S_G2B, S_C_DIV:                        issue_op_in = OP_DIV;
         S_C_PT:                                       issue_op_in = OP_MUL16;
         default:                                      issue_in    = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         pt_mem[wr_addr_in] <= {req_point_x, req_point_y};
      end
      rd_data_ff <= pt_mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff    <= 63'd2147484;
         tolerance_ff    <= 63'd4295;
         max_iter_ff     <= 16'd10000;
         slope_delta_ff  <= 63'd4294967;
         offset_delta_ff <= 63'd4294967;
         start_slope_ff  <= '0;
         start_offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_SIZE:    step_size_ff    <= csr_wdata[62:0];
            CSR_TOLERANCE:    tolerance_ff    <= csr_wdata[62:0];
            CSR_MAX_ITER:     max_iter_ff     <= csr_wdata[15:0];
            CSR_SLOPE_DELTA:  slope_delta_ff  <= csr_wdata[62:0];
            CSR_OFFSET_DELTA: offset_delta_ff <= csr_wdata[62:0];
            CSR_START_SLOPE:  start_slope_ff  <= csr_wdata;
            CSR_START_OFFSET: start_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_LOAD;
         pt_count_ff    <= '0;
         arith_ctl_ff   <= '{start: 1'b0, op: OP_MUL32};
         rsp_valid_ff   <= 1'b0;
         slope_ff       <= '0;
         offset_ff      <= '0;
         slope_prev_ff  <= '0;
         offset_prev_ff <= '0;
         err_ff         <= START_ERR;
         iter_ff        <= '0;
      end else begin
         arith_ctl_ff <= '{start: issue_in, op: issue_op_in};
         if (fin_take_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (wr_en_in) begin
                     pt_count_ff <= pt_count_ff + 1'b1;
                  end
                  if (req_last_point) begin
                     state_ff <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               slope_ff       <= start_slope_ff;
               offset_ff      <= start_offset_ff;
               slope_prev_ff  <= '0;
               offset_prev_ff <= '0;
               err_ff         <= START_ERR;
               iter_ff        <= '0;
               state_ff       <= S_CHECK;
            end
            S_CHECK: begin
               if (err_ff > {1'b0, tolerance_ff}) begin
                  iter_ff  <= iter_ff + 17'd1;
                  state_ff <= (iter_ff < 17'(max_iter_ff)) ? S_SQ1 : S_FINISH;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_SQ1: begin
               opa_ff <= da_in;
               opb_ff <= da_in;
               after_ff <= S_SQ2;
               state_ff <= S_WAIT;
            end
            S_SQ2: begin
               tmp_ff <= arith_res;
               opa_ff <= db_in;
               opb_ff <= db_in;
               after_ff <= S_SQ3;
               state_ff <= S_WAIT;
            end
            S_SQ3: begin
               opa_ff <= sat_add(tmp_ff, arith_res);
               opb_ff <= '0;
               after_ff <= S_STEP;
               state_ff <= S_WAIT;
            end
            S_STEP: begin
               err_ff         <= arith_res;
               slope_prev_ff  <= slope_ff;
               offset_prev_ff <= offset_ff;
               ca_ff       <= slope_ff;
               cb_ff       <= offset_ff;
               cost_ret_ff <= S_G1A;
               state_ff    <= S_C_BEGIN;
            end
            S_G1A: begin
               base_ff     <= cost_ff;
               ca_ff       <= sat_add(slope_ff, ds_in);
               cb_ff       <= offset_ff;
               cost_ret_ff <= S_G1B;
               state_ff    <= S_C_BEGIN;
            end
            S_G1B: begin
               opa_ff <= sat_sub(cost_ff, base_ff);
               opb_ff <= ds_in;
               after_ff <= S_G1C;
               state_ff <= S_WAIT;
            end
            S_G1C: begin
               opa_ff <= {1'b0, step_size_ff};
               opb_ff <= arith_res;
               after_ff <= S_G1D;
               state_ff <= S_WAIT;
            end
            S_G1D: begin
               // offset gradient uses the slope just updated
               slope_ff    <= slope_in;
               ca_ff       <= slope_in;
               cb_ff       <= offset_ff;
               cost_ret_ff <= S_G2A;
               state_ff    <= S_C_BEGIN;
            end
            S_G2A: begin
               base_ff     <= cost_ff;
               ca_ff       <= slope_ff;
               cb_ff       <= sat_add(offset_ff, dof_in);
               cost_ret_ff <= S_G2B;
               state_ff    <= S_C_BEGIN;
            end
            S_G2B: begin
               opa_ff <= sat_sub(cost_ff, base_ff);
               opb_ff <= dof_in;
               after_ff <= S_G2C;
               state_ff <= S_WAIT;
            end
            S_G2C: begin
               opa_ff <= {1'b0, step_size_ff};
               opb_ff <= arith_res;
               after_ff <= S_G2D;
               state_ff <= S_WAIT;
            end
            S_G2D: begin
               offset_ff <= offset_in;
               state_ff  <= S_CHECK;
            end
            // cost pass over the stored points at (ca, cb)
            S_C_BEGIN: begin
               sum_ff    <= '0;
               pt_idx_ff <= '0;
               state_ff  <= (pt_count_ff == '0) ? S_C_DEN : S_C_RD;
            end
            S_C_RD: begin
               state_ff <= S_C_PT;
            end
            S_C_PT: begin
               yq_ff <= {{16{rd_data_ff[31]}}, rd_data_ff[31:0], 16'd0};
               opa_ff <= ca_ff;
               opb_ff <= {{32{rd_data_ff[63]}}, rd_data_ff[63:32]};
               after_ff <= S_C_RES;
               state_ff <= S_WAIT;
            end
            S_C_RES: begin
               opa_ff <= resid_in;
               opb_ff <= resid_in;
               after_ff <= S_C_ACC;
               state_ff <= S_WAIT;
            end
            S_C_ACC: begin
               sum_ff    <= sat_add(sum_ff, arith_res);
               pt_idx_ff <= idx_next_in;
               state_ff  <= (idx_next_in < pt_count_ff) ? S_C_RD : S_C_DEN;
            end
            S_C_DEN: begin
               opa_ff <= ca_ff;
               opb_ff <= ca_ff;
               after_ff <= S_C_DIV;
               state_ff <= S_WAIT;
            end
            S_C_DIV: begin
               opa_ff <= sum_ff;
               opb_ff <= sat_add(ONE_Q32, arith_res);
               after_ff <= S_C_END;
               state_ff <= S_WAIT;
            end
            S_C_END: begin
               cost_ff  <= arith_res;
               state_ff <= cost_ret_ff;
            end
            S_WAIT: begin
               if (arith_sts.done) begin
                  state_ff <= after_ff;
               end
            end
            S_FINISH: begin
               if (fin_take_in) begin
                  rsp_slope_ff  <= slope_ff;
                  rsp_offset_ff <= offset_ff;
                  rsp_iter_ff   <= iter_ff;
                  rsp_step_ff   <= err_ff[62:0];
                  rsp_conv_ff   <= (err_ff <= {1'b0, tolerance_ff});
                  pt_count_ff   <= '0;
                  state_ff      <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   lfgd_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl_ff),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .sts    (arith_sts),
      .result (arith_res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fit_slope       = rsp_slope_ff;
   assign rsp_fit_offset      = rsp_offset_ff;
   assign rsp_iterations_used = rsp_iter_ff;
   assign rsp_final_step      = rsp_step_ff;
   assign rsp_converged       = rsp_conv_ff;

`include "line_fit_gradient_descent_unit_defines.svh"

   `LFGD_ASSERT(a_count_bound, pt_count_ff <= CNT_W'(MAX_POINTS), "point count past store depth")
   `LFGD_ASSERT(a_issue_idle, arith_ctl_ff.start |-> !arith_sts.busy, "arith issue while busy")
   `LFGD_ASSERT(a_rsp_src, $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH), "result beat outside finish")
   `LFGD_ASSERT(a_iter_bound, (state_ff != S_LOAD && state_ff != S_INIT) |-> (iter_ff <= 17'(max_iter_ff) + 17'd1), "iteration count past limit")

endmodule

`default_nettype wire
